// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low
`define EVPA_AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("evpa check failed");

// Next-cycle implication, masked while reset is low
`define EVPA_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("evpa check failed");

`endif

// ===== src/evpa_pkg.sv =====
// Shared types and constants of the voice pool allocator.
// Depends on nothing; the allocator modules and the checker import it.
package evpa_pkg;

    // configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  CFG_POOL_SIZE     = 3'd0;
    localparam logic [2:0]  CFG_MIN_LEVEL     = 3'd1;
    localparam logic [2:0]  CFG_MAX_RANGE     = 3'd2;
    localparam logic [2:0]  CFG_COOLDOWN_US   = 3'd3;
    localparam logic [2:0]  CFG_SAMPLE_PRESENT = 3'd4;

    localparam int          MASK_W      = 10;
    localparam logic [15:0] PITCH_UNITY = 16'd16384;
    localparam logic [19:0] PITCH_MIN   = 20'd8192;
    localparam logic [19:0] PITCH_MAX   = 20'd32768;
    localparam logic [15:0] RATE_UNITY  = 16'd256;
    // ceil(2^25 / 5): rate*64/5 == (rate * DIV5_RECIP) >> 19 for 16-bit rate
    localparam logic [22:0] DIV5_RECIP  = 23'd6710887;
    localparam logic [6:0]  POOL_MAX    = 7'd64;

    typedef enum logic [2:0] {
        OC_COOLDOWN  = 3'd0,
        OC_TOO_FAR   = 3'd1,
        OC_TOO_QUIET = 3'd2,
        OC_NO_SAMPLE = 3'd3,
        OC_VIRTUAL   = 3'd4,
        OC_STARTED   = 3'd5
    } t_outcome;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic cool;
        logic sq;
        logic rng;
        logic sqrt;
        logic div;
        logic prio;
        logic scan;
        logic fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [4:0] cnt;
        logic       cool_rej;
        logic       rng_rej;
        logic       full;
        logic       out_busy;
    } t_stat;

    // per-kind mask bit; kinds past the mask width read as clear
    function automatic logic kbit(input logic [MASK_W-1:0] m, input int unsigned i);
        logic b;
        b = 1'b0;
        if (i < MASK_W) begin
            b = m[i[3:0]];
        end
        return b;
    endfunction

endpackage

// ===== src/evpa_if.sv =====
// Event and result channel interfaces (valid/ready).
// Depends on nothing.
interface evpa_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  event_kind;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic signed [23:0] src_z;
    logic signed [23:0] lis_x;
    logic signed [23:0] lis_y;
    logic signed [23:0] lis_z;
    logic        [15:0] intensity;
    logic        [15:0] rate;
    logic        [47:0] now_us;
    logic        [9:0]  playing_mask;

    modport source (output valid, event_kind, src_x, src_y, src_z, lis_x, lis_y, lis_z,
                    intensity, rate, now_us, playing_mask, input ready);
    modport sink   (input valid, event_kind, src_x, src_y, src_z, lis_x, lis_y, lis_z,
                    intensity, rate, now_us, playing_mask, output ready);
endinterface

interface evpa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic        steal_valid;
    logic [3:0]  steal_kind;
    logic [15:0] volume;
    logic [15:0] pitch;
    logic [15:0] priority_res;
    logic [6:0]  active_count;

    modport source (output valid, outcome, steal_valid, steal_kind, volume, pitch,
                    priority_res, active_count, input ready);
    modport sink   (input valid, outcome, steal_valid, steal_kind, volume, pitch,
                    priority_res, active_count, output ready);
endinterface

// ===== src/event_voice_pool_allocator.sv =====
// Voice pool allocator: takes one sound event word at a time, rejects it on
// cooldown, range, level or missing sample, computes its priority (square
// root of the squared distance, then a 17-step divide by the range) and,
// with the pool full, steals the weakest lower-priority playing voice.
// An event rejected at the cooldown check ends there, one rejected at the
// range check ends after the squares and that check, and any other event
// runs 25 root steps, 17 divide steps and, when the pool is full, one scan
// step per kind; one event is in work at a time. The result word sits in an
// output register, and the next event is taken while it waits.
// Depends on evpa_pkg, evpa_if, evpa_ctrl and evpa_dp.
module event_voice_pool_allocator
    import evpa_pkg::*;
#(
    parameter int NUM_KINDS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    evpa_in_if.sink              i_evt,
    evpa_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    evpa_ctrl #(
        .NUM_KINDS (NUM_KINDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    evpa_dp #(
        .NUM_KINDS (NUM_KINDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (i_evt),
        .o_res       (o_res),
        .i_in_ready  (w_in_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ===== src/evpa_ctrl.sv =====
// Sequencer of the allocator: steps one event through its phases.
// Depends on evpa_pkg.
module evpa_ctrl
    import evpa_pkg::*;
#(
    parameter int NUM_KINDS = 10
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_COOL = 9'b000000010,
        S_SQ   = 9'b000000100,
        S_RNG  = 9'b000001000,
        S_SQRT = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_PRIO = 9'b001000000,
        S_SCAN = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.clr  = 1'b1;
                    n_state    = S_COOL;
                end
            end
            S_COOL: begin
                o_cmd.cool = 1'b1;
                o_cmd.clr  = 1'b1;
                n_state    = i_stat.cool_rej ? S_FIN : S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                if (i_stat.cnt == 5'd4) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_RNG;
                end
            end
            S_RNG: begin
                o_cmd.rng = 1'b1;
                o_cmd.clr = 1'b1;
                n_state   = i_stat.rng_rej ? S_FIN : S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt = 1'b1;
                if (i_stat.cnt == 5'd24) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.cnt == 5'd16) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_PRIO;
                end
            end
            S_PRIO: begin
                o_cmd.prio = 1'b1;
                o_cmd.clr  = 1'b1;
                n_state    = i_stat.full ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.cnt == 5'(NUM_KINDS - 1)) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                // wait until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/evpa_dp.sv =====
// Datapath of the allocator: config, per-kind state, square root, divider,
// weakest-voice scan and the output register. Depends on evpa_pkg, evpa_if.
module evpa_dp
    import evpa_pkg::*;
#(
    parameter int NUM_KINDS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    evpa_in_if.sink              i_evt,
    evpa_out_if.source           o_res,
    input  logic                 i_in_ready,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int KW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

    // configuration
    logic [6:0]  r_pool_size;
    logic [15:0] r_min_level;
    logic [22:0] r_max_range;
    logic [31:0] r_cooldown;
    logic [9:0]  r_sample;

    // captured event
    logic [3:0]  r_kind;
    logic [23:0] r_src_x, r_src_y, r_src_z, r_lis_x, r_lis_y, r_lis_z;
    logic [15:0] r_intensity, r_rate;
    logic [47:0] r_now;
    logic [9:0]  r_play;

    // working registers
    logic [4:0]  r_cnt;
    logic [23:0] r_ad0, r_ad1, r_ad2;
    logic [19:0] r_pq;
    logic [47:0] r_prod;
    logic [49:0] r_sum;
    logic [45:0] r_mr2;
    logic [49:0] r_rem, r_res, r_bit;
    logic [23:0] r_drem;
    logic [16:0] r_q;
    logic [15:0] r_prio;
    logic [15:0] r_wpri;
    logic        r_wfound;
    logic [KW-1:0] r_widx;
    logic        r_full;
    t_outcome    r_outcome;
    logic        r_rec;

    // per-kind state
    logic [47:0] r_last [NUM_KINDS];
    logic        r_seen [NUM_KINDS];
    logic [15:0] r_vp   [NUM_KINDS];
    logic [6:0]  r_active;

    // output register
    logic        r_ov;
    t_outcome    r_o_outcome;
    logic        r_o_steal_valid;
    logic [3:0]  r_o_steal_kind;
    logic [15:0] r_o_volume, r_o_pitch, r_o_prio;
    logic [6:0]  r_o_active;

    function automatic logic [23:0] absdiff(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] d;
        d = {a[23], a} - {b[23], b};
        return d[24] ? 24'(-d) : d[23:0];
    endfunction

    // effective pool size, clamped to 1..64
    logic [6:0] w_pool;
    assign w_pool = (r_pool_size == 7'd0) ? 7'd1 :
                    (r_pool_size > POOL_MAX) ? POOL_MAX : r_pool_size;

    logic [KW-1:0] w_k;
    logic          w_kok;
    assign w_k   = KW'(r_kind);
    assign w_kok = (32'(r_kind) < 32'(NUM_KINDS));

    // cooldown check
    logic [48:0] w_tdiff;
    logic        w_cool_hit;
    assign w_tdiff    = {1'b0, r_now} - {1'b0, r_last[w_k]};
    assign w_cool_hit = r_seen[w_k] && (w_tdiff[48] || (w_tdiff[47:0] < {16'd0, r_cooldown}));

    // squarer shared by the three axes and the range limit
    logic [23:0] w_mop;
    logic [47:0] w_sqr;
    always_comb begin
        case (r_cnt)
            5'd0:    w_mop = r_ad0;
            5'd1:    w_mop = r_ad1;
            5'd2:    w_mop = r_ad2;
            default: w_mop = {1'b0, r_max_range};
        endcase
    end
    assign w_sqr = 48'(w_mop) * 48'(w_mop);

    logic [38:0] w_rmul;
    assign w_rmul = 39'(r_rate) * 39'(DIV5_RECIP);

    // range, level and sample checks
    logic w_far, w_quiet, w_nosmp;
    assign w_far   = r_sum > 50'(r_mr2);
    assign w_quiet = r_intensity < r_min_level;
    assign w_nosmp = !kbit(r_sample, 32'(r_kind));

    // square root step
    logic [49:0] w_trial;
    assign w_trial = r_res + r_bit;

    // divider step: d * 65536 / max_range, one quotient bit a cycle
    logic [23:0] w_dnum;
    logic        w_dge;
    assign w_dnum = (r_cnt == 5'd0) ? r_res[23:0] : {r_drem[22:0], 1'b0};
    assign w_dge  = w_dnum >= {1'b0, r_max_range};

    // priority
    logic [16:0] w_factor;
    logic [32:0] w_pmul;
    assign w_factor = r_q[16] ? 17'd0 : (17'd65536 - r_q);
    assign w_pmul   = 33'(r_intensity) * 33'(w_factor);

    // scan candidate
    logic [KW-1:0] w_si;
    logic          w_cand;
    assign w_si   = r_cnt[KW-1:0];
    assign w_cand = kbit(r_sample, 32'(r_cnt)) && kbit(r_play, 32'(r_cnt)) &&
                    (r_vp[w_si] < r_wpri);

    // final decision and recount
    logic        w_virt, w_start;
    logic [9:0]  w_play2;
    logic [5:0]  w_cnt;
    logic [6:0]  w_newact, w_oldact;
    logic [15:0] w_pitch;
    assign w_virt  = (r_outcome == OC_STARTED) && r_full && !r_wfound;
    assign w_start = (r_outcome == OC_STARTED) && !w_virt;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            w_play2[i] = (r_play[i] && !(r_full && (32'(r_widx) == i))) ||
                         (32'(r_kind) == i);
        end
        w_cnt = '0;
        for (int i = 0; i < NUM_KINDS; i++) begin
            w_cnt = w_cnt + 6'(kbit(r_sample, i) && kbit(w_play2, i));
        end
    end
    assign w_newact = (7'(w_cnt) < w_pool) ? 7'(w_cnt) : w_pool;
    assign w_oldact = (r_active < w_pool) ? r_active : w_pool;
    assign w_pitch  = (r_rate <= RATE_UNITY) ? PITCH_UNITY :
                      (r_pq < PITCH_MIN) ? PITCH_MIN[15:0] :
                      (r_pq > PITCH_MAX) ? PITCH_MAX[15:0] : r_pq[15:0];

    // status to the controller
    assign o_stat.cnt      = r_cnt;
    assign o_stat.cool_rej = !w_kok || w_cool_hit;
    assign o_stat.rng_rej  = w_far || w_quiet || w_nosmp;
    assign o_stat.full     = (r_active >= w_pool);
    assign o_stat.out_busy = r_ov;

    assign i_evt.ready = i_in_ready;

    // control and per-kind state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= 7'd8;
            r_min_level <= 16'd0;
            r_max_range <= 23'd51200;
            r_cooldown  <= 32'd0;
            r_sample    <= 10'h3FF;
            r_active    <= 7'd0;
            r_ov        <= 1'b0;
            for (int i = 0; i < NUM_KINDS; i++) begin
                r_seen[i] <= 1'b0;
                r_vp[i]   <= 16'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_SIZE:      r_pool_size <= i_cfg_wdata[6:0];
                    CFG_MIN_LEVEL:      r_min_level <= i_cfg_wdata[15:0];
                    CFG_MAX_RANGE:      r_max_range <= i_cfg_wdata[22:0];
                    CFG_COOLDOWN_US:    r_cooldown  <= i_cfg_wdata;
                    CFG_SAMPLE_PRESENT: r_sample    <= i_cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_ov <= 1'b1;
                if (w_start || w_virt || r_rec) begin
                    r_seen[w_k] <= 1'b1;
                end
                if (w_start) begin
                    r_vp[w_k] <= r_prio;
                    r_active  <= w_newact;
                end
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_cnt <= i_cmd.clr ? 5'd0 : r_cnt + 5'd1;
        if (i_cmd.load) begin
            r_kind      <= i_evt.event_kind;
            r_src_x     <= i_evt.src_x;
            r_src_y     <= i_evt.src_y;
            r_src_z     <= i_evt.src_z;
            r_lis_x     <= i_evt.lis_x;
            r_lis_y     <= i_evt.lis_y;
            r_lis_z     <= i_evt.lis_z;
            r_intensity <= i_evt.intensity;
            r_rate      <= i_evt.rate;
            r_now       <= i_evt.now_us;
            r_play      <= i_evt.playing_mask;
        end
        if (i_cmd.cool) begin
            r_outcome <= w_kok ? OC_COOLDOWN : OC_NO_SAMPLE;
            r_rec     <= 1'b0;
            r_full    <= 1'b0;
            r_ad0     <= absdiff(r_src_x, r_lis_x);
            r_ad1     <= absdiff(r_src_y, r_lis_y);
            r_ad2     <= absdiff(r_src_z, r_lis_z);
            r_pq      <= w_rmul[38:19];
        end
        // squares: product registered, accumulated in the following cycle
        if (i_cmd.sq) begin
            if (r_cnt < 5'd4) begin
                r_prod <= w_sqr;
            end
            if (r_cnt == 5'd1) begin
                r_sum <= 50'(r_prod);
            end else if (r_cnt == 5'd2 || r_cnt == 5'd3) begin
                r_sum <= r_sum + 50'(r_prod);
            end else if (r_cnt == 5'd4) begin
                r_mr2 <= r_prod[45:0];
            end
        end
        if (i_cmd.rng) begin
            r_outcome <= w_far ? OC_TOO_FAR : (w_quiet ? OC_TOO_QUIET : OC_NO_SAMPLE);
            r_rec     <= !w_far && !w_quiet;
            r_rem     <= r_sum;
            r_res     <= '0;
            r_bit     <= 50'd1 << 48;
        end
        // one root bit a cycle
        if (i_cmd.sqrt) begin
            if (r_rem >= w_trial) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div) begin
            r_drem <= w_dge ? (w_dnum - {1'b0, r_max_range}) : w_dnum;
            r_q    <= {r_q[15:0], w_dge};
        end
        if (i_cmd.prio) begin
            r_prio    <= w_pmul[31:16];
            r_wpri    <= w_pmul[31:16];
            r_wfound  <= 1'b0;
            r_widx    <= '0;
            r_full    <= o_stat.full;
            r_outcome <= OC_STARTED;
        end
        // weakest lower-priority voice, first kind wins ties
        if (i_cmd.scan && w_cand) begin
            r_wpri   <= r_vp[w_si];
            r_widx   <= w_si;
            r_wfound <= 1'b1;
        end
        if (i_cmd.fin) begin
            if (w_start || w_virt || r_rec) begin
                r_last[w_k] <= r_now;
            end
            r_o_outcome     <= w_virt ? OC_VIRTUAL : r_outcome;
            r_o_steal_valid <= w_start && r_full;
            r_o_steal_kind  <= (w_start && r_full) ? 4'(r_widx) : 4'd0;
            r_o_volume      <= w_start ? r_intensity : 16'd0;
            r_o_pitch       <= w_start ? w_pitch : PITCH_UNITY;
            r_o_prio        <= (r_outcome == OC_STARTED) ? r_prio : 16'd0;
            r_o_active      <= w_start ? w_newact : w_oldact;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.outcome      = r_o_outcome;
    assign o_res.steal_valid  = r_o_steal_valid;
    assign o_res.steal_kind   = r_o_steal_kind;
    assign o_res.volume       = r_o_volume;
    assign o_res.pitch        = r_o_pitch;
    assign o_res.priority_res = r_o_prio;
    assign o_res.active_count = r_o_active;

endmodule

// ===== src/evpa_checker.sv =====
// Port-level checks on the allocator result channel, bound to the top level.
// Depends on evpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module evpa_checker
    import evpa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_outcome,
    input logic        i_steal_valid,
    input logic [15:0] i_volume,
    input logic [15:0] i_pitch,
    input logic [15:0] i_prio
);

    // a stalled result word holds
    `EVPA_AST_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_outcome) && $stable(i_pitch))
    // a steal only comes with a start
    `EVPA_AST_NOW(a_steal, i_clk, i_rst_n, i_valid && i_steal_valid, i_outcome == 3'(OC_STARTED))
    // no start: neutral volume and pitch
    `EVPA_AST_NOW(a_idle_fields, i_clk, i_rst_n, i_valid && i_outcome != 3'(OC_STARTED), i_volume == 16'd0 && i_pitch == PITCH_UNITY)
    // early rejects carry no priority
    `EVPA_AST_NOW(a_rej_prio, i_clk, i_rst_n, i_valid && i_outcome != 3'(OC_STARTED) && i_outcome != 3'(OC_VIRTUAL), i_prio == 16'd0)

endmodule

bind event_voice_pool_allocator evpa_checker u_evpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_outcome     (o_res.outcome),
    .i_steal_valid (o_res.steal_valid),
    .i_volume      (o_res.volume),
    .i_pitch       (o_res.pitch),
    .i_prio        (o_res.priority_res)
);
